// ===== design/assert_macros.svh =====
// Assertion macros shared by the PWM generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property check on the rising clock edge, disabled during reset.
`define MCPWM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Condition that must never be seen on a rising clock edge.
`define MCPWM_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");

`else

`define MCPWM_ASSERT(label, clk, rst, prop)
`define MCPWM_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== design/mcpwm_pkg.sv =====
// Shared types, command and status codes of the PWM generator.
`timescale 1ns / 1ps

package mcpwm_pkg;

   localparam int NUM_CHANNELS_DEFAULT = 8;

   // Command codes
   localparam logic [2:0] CMD_ADD        = 3'd0;
   localparam logic [2:0] CMD_REMOVE     = 3'd1;
   localparam logic [2:0] CMD_SET_DUTY   = 3'd2;
   localparam logic [2:0] CMD_SET_PERIOD = 3'd3;
   localparam logic [2:0] CMD_TICK       = 3'd4;

   // Status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_BAD_SLOT = 2'd2;

   // Duty that means full on, also the on-time divisor
   localparam logic [7:0] FULL_DUTY = 8'd255;
   localparam logic [7:0] DIVISOR   = 8'd255;

   // duty * period product and its byte-serial division
   localparam int PROD_W    = 40;
   localparam int DIV_STEPS = PROD_W / 8;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Number of slots visible in the levels and changed fields
   localparam int VIEW_W = 8;

   typedef struct packed {
      logic [2:0]  command;
      logic [3:0]  slot;
      logic [7:0]  pin_number;
      logic [7:0]  duty;
      logic [31:0] period_value;
      logic [31:0] now_us;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] added_slot;
      logic [7:0] levels;
      logic [7:0] changed;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic find_free;
      logic set_full;
      logic set_bad;
      logic use_slot;
      logic remove_slot;
      logic mul;
      logic div_step;
      logic write_slot;
      logic tick_clear;
      logic tick_slot;
      logic load_rsp;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [2:0] command;
      logic       free_found;
      logic       slot_ok;
      logic       div_last;
      logic       tick_last;
      logic       rsp_busy;
   } dp_status_type;

endpackage

// ===== design/multi_channel_pwm_generator.sv =====
// Top level of the multi-channel PWM generator.
`timescale 1ns / 1ps

// Table of NUM_CHANNELS PWM slots driven by add, remove, set duty, set
// period and tick transactions; every transaction returns one result with
// the status, the slot taken by an add, and the levels and changed bits of
// slots 0 to 7. One transaction is in work at a time. For add, set duty and
// set period the on-time duty*period/255 is formed by one 8x32 multiply and
// a byte-serial divide by 255. A tick is handled by the single tick unit
// that walks the slots one per cycle. Remove, rejected and unknown commands
// go from decode straight to the result. A new transaction is accepted
// while the previous result still waits in the output register.
module multi_channel_pwm_generator #(
   parameter int NUM_CHANNELS = mcpwm_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mcpwm_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mcpwm_pkg::rsp_type rsp_data
);

   mcpwm_pkg::ctrl_cmd_type  cmd;
   mcpwm_pkg::dp_status_type st;

   // Sequencer
   mcpwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // Slot table and arithmetic
   mcpwm_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .st        (st),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/mcpwm_ctrl.sv =====
// Sequencing state machine of the PWM generator.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcpwm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mcpwm_pkg::dp_status_type st,
   output mcpwm_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_MUL    = 7'b0000100,
      ST_DIV    = 7'b0001000,
      ST_WRITE  = 7'b0010000,
      ST_TICK   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Only the idle state takes a new transaction
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (st.command)
               mcpwm_pkg::CMD_ADD: begin
                  if (st.free_found) begin
                     cmd.find_free = 1'b1;
                     state_in      = ST_MUL;
                  end else begin
                     cmd.set_full = 1'b1;
                     state_in     = ST_FINISH;
                  end
               end
               mcpwm_pkg::CMD_REMOVE: begin
                  if (st.slot_ok) begin
                     cmd.remove_slot = 1'b1;
                  end else begin
                     cmd.set_bad = 1'b1;
                  end
                  state_in = ST_FINISH;
               end
               mcpwm_pkg::CMD_SET_DUTY, mcpwm_pkg::CMD_SET_PERIOD: begin
                  if (st.slot_ok) begin
                     cmd.use_slot = 1'b1;
                     state_in     = ST_MUL;
                  end else begin
                     cmd.set_bad = 1'b1;
                     state_in    = ST_FINISH;
                  end
               end
               mcpwm_pkg::CMD_TICK: begin
                  cmd.tick_clear = 1'b1;
                  state_in       = ST_TICK;
               end
               default: begin
                  // unknown codes just report their levels
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_slot = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_TICK: begin
            cmd.tick_slot = 1'b1;
            if (st.tick_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!st.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted transaction is decoded on the next cycle
   `MCPWM_ASSERT(a_accept_decodes, clock, reset, (req_valid && !req_stall) |=> (state_ff == ST_DECODE))
   // A result held up by the output side keeps the machine waiting
   `MCPWM_ASSERT(a_finish_waits, clock, reset, (state_ff == ST_FINISH && st.rsp_busy) |=> (state_ff == ST_FINISH))
   // The slot walk does not leave before its last slot
   `MCPWM_ASSERT(a_tick_walks, clock, reset, (state_ff == ST_TICK && !st.tick_last) |=> (state_ff == ST_TICK))

endmodule

// ===== design/mcpwm_datapath.sv =====
// Slot table, on-time multiply and divide, tick unit and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcpwm_datapath #(
   parameter int NUM_CHANNELS = mcpwm_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mcpwm_pkg::req_type       req_data,
   input  mcpwm_pkg::ctrl_cmd_type  cmd,
   output mcpwm_pkg::dp_status_type st,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mcpwm_pkg::rsp_type       rsp_data
);

   localparam int IDXW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int VIEW = (NUM_CHANNELS < mcpwm_pkg::VIEW_W) ? NUM_CHANNELS : mcpwm_pkg::VIEW_W;
   localparam int PW   = mcpwm_pkg::PROD_W;

   // Captured transaction and bookkeeping
   mcpwm_pkg::req_type               req_ff;
   logic [IDXW-1:0]                  idx_ff;
   logic [1:0]                       status_ff;
   logic [2:0]                       added_ff;
   logic [mcpwm_pkg::VIEW_W-1:0]     before_ff;

   // Slot table; the pin tag never affects the levels and is not kept
   logic [NUM_CHANNELS-1:0]          valid_ff;
   logic [NUM_CHANNELS-1:0]          level_ff;
   logic [7:0]                       duty_ff   [NUM_CHANNELS];
   logic [31:0]                      period_ff [NUM_CHANNELS];
   logic [31:0]                      on_ff     [NUM_CHANNELS];
   logic [31:0]                      last_ff   [NUM_CHANNELS];

   // On-time arithmetic
   logic [PW-1:0]                    prod_ff;
   logic [PW-1:0]                    prod_in;
   logic [7:0]                       rem_ff;
   logic [7:0]                       rem_in;
   logic [31:0]                      quo_ff;
   logic [31:0]                      quo_in;
   logic [mcpwm_pkg::DIV_CNT_W-1:0]  cnt_ff;

   // Result register
   mcpwm_pkg::rsp_type               rsp_ff;
   logic                             rsp_valid_ff;

   logic                             free_found;
   logic [IDXW-1:0]                  free_idx;
   logic [IDXW-1:0]                  slot_sel;
   logic                             slot_ok;
   logic [mcpwm_pkg::VIEW_W-1:0]     levels_now;
   logic [7:0]                       mul_duty;
   logic [31:0]                      wr_period;
   logic [7:0]                       digit;
   logic [8:0]                       digit_sum;
   logic                             digit_ge;
   logic [31:0]                      elapsed;
   logic [31:0]                      low_time;
   logic                             tick_upd;
   logic                             tick_lvl;

   // Lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDXW'(i);
         end
      end
   end

   // Slot check for remove and set
   assign slot_sel = req_ff.slot[IDXW-1:0];
   assign slot_ok  = (int'(req_ff.slot) < NUM_CHANNELS) && valid_ff[slot_sel];

   // Visible levels
   always_comb begin
      levels_now = '0;
      for (int i = 0; i < VIEW; i++) begin
         levels_now[i] = level_ff[i];
      end
   end

   // Multiply operands: set commands take the kept half from the table
   assign mul_duty  = (req_ff.command == mcpwm_pkg::CMD_SET_PERIOD) ? duty_ff[idx_ff]
                                                                    : req_ff.duty;
   assign wr_period = (req_ff.command == mcpwm_pkg::CMD_SET_DUTY) ? period_ff[idx_ff]
                                                                  : req_ff.period_value;
   assign prod_in   = {32'd0, mul_duty} * {8'd0, wr_period};

   // Division by 255 one byte a step: 256 = 255 + 1, so each quotient
   // digit is the remainder plus one if remainder plus byte reaches 255
   assign digit     = prod_ff[PW-1 -: 8];
   assign digit_sum = {1'b0, rem_ff} + {1'b0, digit};
   assign digit_ge  = (digit_sum >= {1'b0, mcpwm_pkg::DIVISOR});
   assign rem_in    = digit_ge ? 8'(digit_sum - {1'b0, mcpwm_pkg::DIVISOR}) : digit_sum[7:0];
   assign quo_in    = {quo_ff[23:0], 8'(rem_ff + {7'd0, digit_ge})};

   // Tick decision for the slot under the walk index
   assign elapsed  = req_ff.now_us - last_ff[idx_ff];
   assign low_time = period_ff[idx_ff] - on_ff[idx_ff];

   always_comb begin
      tick_upd = 1'b0;
      tick_lvl = level_ff[idx_ff];
      if (duty_ff[idx_ff] == 8'd0) begin
         tick_upd = 1'b1;
         tick_lvl = 1'b0;
      end else if (duty_ff[idx_ff] == mcpwm_pkg::FULL_DUTY) begin
         tick_upd = 1'b1;
         tick_lvl = 1'b1;
      end else if (!level_ff[idx_ff]) begin
         if (elapsed >= low_time) begin
            tick_upd = 1'b1;
            tick_lvl = 1'b1;
         end
      end else if (elapsed >= on_ff[idx_ff]) begin
         tick_upd = 1'b1;
         tick_lvl = 1'b0;
      end
   end

   // Control state: valid and level bits, index, divider counters, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         level_ff     <= '0;
         idx_ff       <= '0;
         rem_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.find_free) begin
            idx_ff <= free_idx;
         end
         if (cmd.use_slot) begin
            idx_ff <= slot_sel;
         end
         if (cmd.tick_clear) begin
            idx_ff <= '0;
         end
         if (cmd.remove_slot) begin
            valid_ff[slot_sel] <= 1'b0;
            level_ff[slot_sel] <= 1'b0;
         end
         if (cmd.mul) begin
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         if (cmd.div_step) begin
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.write_slot && req_ff.command == mcpwm_pkg::CMD_ADD) begin
            valid_ff[idx_ff] <= 1'b1;
            level_ff[idx_ff] <= 1'b0;
         end
         if (cmd.tick_slot) begin
            if (valid_ff[idx_ff] && tick_upd) begin
               level_ff[idx_ff] <= tick_lvl;
            end
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: captured transaction, table contents, arithmetic, result
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff    <= req_data;
         status_ff <= mcpwm_pkg::STAT_OK;
         added_ff  <= '0;
         before_ff <= levels_now;
      end
      if (cmd.set_full) begin
         status_ff <= mcpwm_pkg::STAT_FULL;
      end
      if (cmd.set_bad) begin
         status_ff <= mcpwm_pkg::STAT_BAD_SLOT;
      end
      if (cmd.find_free) begin
         added_ff <= 3'(free_idx);
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
         quo_ff  <= '0;
      end
      if (cmd.div_step) begin
         prod_ff <= {prod_ff[PW-9:0], 8'd0};
         quo_ff  <= quo_in;
      end
      if (cmd.write_slot) begin
         unique case (req_ff.command)
            mcpwm_pkg::CMD_ADD: begin
               duty_ff[idx_ff]   <= req_ff.duty;
               period_ff[idx_ff] <= req_ff.period_value;
               on_ff[idx_ff]     <= quo_ff;
               last_ff[idx_ff]   <= req_ff.now_us;
            end
            mcpwm_pkg::CMD_SET_DUTY: begin
               duty_ff[idx_ff] <= req_ff.duty;
               on_ff[idx_ff]   <= quo_ff;
            end
            mcpwm_pkg::CMD_SET_PERIOD: begin
               period_ff[idx_ff] <= req_ff.period_value;
               on_ff[idx_ff]     <= quo_ff;
            end
            default: begin
            end
         endcase
      end
      if (cmd.tick_slot && valid_ff[idx_ff] && tick_upd) begin
         last_ff[idx_ff] <= req_ff.now_us;
      end
      if (cmd.load_rsp) begin
         rsp_ff.status     <= status_ff;
         rsp_ff.added_slot <= added_ff;
         rsp_ff.levels     <= levels_now;
         rsp_ff.changed    <= levels_now ^ before_ff;
      end
   end

   // Status to the controller
   assign st.command    = req_ff.command;
   assign st.free_found = free_found;
   assign st.slot_ok    = slot_ok;
   assign st.div_last   = (cnt_ff == mcpwm_pkg::DIV_CNT_W'(mcpwm_pkg::DIV_STEPS - 1));
   assign st.tick_last  = (idx_ff == IDXW'(NUM_CHANNELS - 1));
   assign st.rsp_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Division remainder stays below the divisor
   `MCPWM_NEVER(a_rem_below_divisor, clock, reset, rem_ff == mcpwm_pkg::DIVISOR)
   // A stored on-time never exceeds its period
   `MCPWM_ASSERT(a_on_within_period, clock, reset, cmd.write_slot |-> (quo_ff <= wr_period))
   // The slot walk stays inside the table
   `MCPWM_ASSERT(a_tick_in_range, clock, reset, cmd.tick_slot |-> (idx_ff <= IDXW'(NUM_CHANNELS - 1)))

endmodule
